// ===== rtl/tss_pkg.sv =====
// ----------------------------------------------------------------------------
// tss_pkg
// Shared types, constants and helper functions for the Taylor-series sine
// block: command/status bundles between controller and datapath, operand
// select codes for the shared multiplier and divider, and fixed constants.
// ----------------------------------------------------------------------------
package tss_pkg;

    // Default configuration
    localparam int TSS_MAX_TERMS = 12;
    localparam int TSS_FRAC_BITS = 30;

    // Fixed formats
    localparam int TSS_OUT_FRAC  = 30;
    localparam int TSS_THR_W     = 31;
    localparam int TSS_USED_W    = 5;
    localparam int TSS_IDX_W     = 4;   // term index, up to sixteen terms
    localparam int TSS_DIV_D_W   = 15;  // divisor width, holds 23040
    localparam int TSS_DIGIT_W   = 4;   // divider retires one hex digit per cycle
    localparam int TSS_CHUNK_W   = 16;  // multiplier consumes 16 bits per cycle

    localparam int TSS_HALF_TURN = 23040;  // 180 degrees in 1/128 degree units
    localparam logic [TSS_THR_W-1:0] TSS_THR_RESET = 31'd1074;

    // pi with 60 fraction bits
    localparam logic [63:0] TSS_PI60 = 64'h3243_F6A8_885A_308D;

    // Multiplier operand selection
    typedef enum logic [1:0] {
        MUL_CONV = 2'd0,   // |angle| * pi
        MUL_SQ   = 2'd1,   // x * x
        MUL_TERM = 2'd2    // term * x^2
    } tss_mul_op_t;

    // Divider operand selection
    typedef enum logic {
        DIV_CONV = 1'b0,   // degrees to radians, divide by half turn
        DIV_TERM = 1'b1    // term / ((2i)(2i+1))
    } tss_div_op_t;

    // Controller to datapath
    typedef struct packed {
        logic                 load;
        logic                 mul_go;
        tss_mul_op_t          mul_op;
        logic                 div_go;
        tss_div_op_t          div_op;
        logic                 take_x;
        logic                 take_x2;
        logic                 take_term;
        logic                 accum;
        logic                 fin_abs;
        logic                 fin_rnd;
        logic [TSS_IDX_W-1:0] term_idx;
    } tss_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic oor;
        logic term_small;
        logic mul_done;
        logic div_done;
    } tss_stat_t;

    // pi rounded to frac-1 fraction bits
    function automatic logic [63:0] tss_piq(input int frac);
        return (TSS_PI60 + (64'd1 << (60 - frac))) >> (61 - frac);
    endfunction

    // Half of the term divisor: i * (2i + 1)
    function automatic logic [TSS_DIV_D_W-1:0] tss_half_divisor(
        input logic [TSS_IDX_W-1:0] idx
    );
        logic [TSS_DIV_D_W-1:0] i;
        i = TSS_DIV_D_W'(idx);
        return TSS_DIV_D_W'(i * ((i << 1) + TSS_DIV_D_W'(1)));
    endfunction

endpackage

// ===== rtl/taylor_series_sine.sv =====
// ----------------------------------------------------------------------------
// taylor_series_sine
// Sine of an angle in 1/128 degree units by summing the Maclaurin series.
// Input beat (in_valid/in_ready): angle_deg. Output beat (out_valid/
// out_ready): sine_value (Q1.30), terms_used, out_of_range. Config beat
// (cfg_valid/cfg_ready): term_threshold, always ready, reset value 1074.
// One angle is processed at a time; in_ready is high only while idle, so
// with a free output register the next angle can be taken in the cycle
// after the result is loaded, and not before the last angle is through.
// An out-of-range angle skips the series. Each term costs one pass
// through the shared multiplier (16 bits of one operand per cycle) and
// one through the radix-16 divider (one digit per cycle), then a
// threshold check.
// The result sits in an output register; a new angle is accepted while it
// waits. If the receiver stalls, the next result is held inside until the
// output register frees. Reset empties the output register and returns the
// sequencer to idle.
// ----------------------------------------------------------------------------
module taylor_series_sine
    import tss_pkg::*;
#(
    parameter int MAX_TERMS = TSS_MAX_TERMS,
    parameter int FRAC_BITS = TSS_FRAC_BITS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic signed [15:0]     angle_deg,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic signed [31:0]     sine_value,
    output logic [TSS_USED_W-1:0]  terms_used,
    output logic                   out_of_range,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [TSS_THR_W-1:0]   term_threshold
);

    logic [TSS_THR_W-1:0]  thr_reg;
    logic                  out_valid_reg;
    logic signed [31:0]    sine_reg;
    logic [TSS_USED_W-1:0] used_reg;
    logic                  oor_reg;

    tss_cmd_t              cmd;
    tss_stat_t             stat;
    logic                  out_free;
    logic                  result_load;
    logic signed [31:0]    res_sine;
    logic [TSS_USED_W-1:0] res_used;
    logic                  res_oor;

    // threshold register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= TSS_THR_RESET;
        end
        else if (cfg_valid)
        begin
            thr_reg <= term_threshold;
        end
    end

    tss_ctrl #(
        .MAX_TERMS (MAX_TERMS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .out_free    (out_free),
        .result_load (result_load),
        .cmd         (cmd),
        .stat        (stat)
    );

    tss_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .angle_deg (angle_deg),
        .thr       (thr_reg),
        .cmd       (cmd),
        .stat      (stat),
        .res_sine  (res_sine),
        .res_used  (res_used),
        .res_oor   (res_oor)
    );

    // output register
    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (result_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result_load)
        begin
            sine_reg <= res_sine;
            used_reg <= res_used;
            oor_reg  <= res_oor;
        end
    end

    assign out_valid    = out_valid_reg;
    assign sine_value   = sine_reg;
    assign terms_used   = used_reg;
    assign out_of_range = oor_reg;

endmodule

// ===== rtl/tss_mul.sv =====
// ----------------------------------------------------------------------------
// tss_mul
// Iterative unsigned multiplier. Operand b is consumed 16 bits per cycle,
// most significant chunk first; done pulses for one cycle when the product
// is ready and the product holds until the next start.
// ----------------------------------------------------------------------------
module tss_mul
    import tss_pkg::*;
#(
    parameter int A_W = 34,
    parameter int B_W = 34
) (
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  logic                                           start,
    input  logic [A_W-1:0]                                 a,
    input  logic [B_W-1:0]                                 b,
    output logic                                           done,
    output logic [A_W+((B_W+TSS_CHUNK_W-1)/TSS_CHUNK_W)*TSS_CHUNK_W-1:0] prod
);

    localparam int NCH   = (B_W + TSS_CHUNK_W - 1) / TSS_CHUNK_W;
    localparam int B_PAD = NCH * TSS_CHUNK_W;
    localparam int P_W   = A_W + B_PAD;
    localparam int CNT_W = $clog2(NCH + 1);

    logic [A_W-1:0]             a_reg;
    logic [B_PAD-1:0]           b_reg;
    logic [P_W-1:0]             acc_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic                       busy_reg;
    logic                       done_reg;
    logic [A_W+TSS_CHUNK_W-1:0] part;

    // one partial product per cycle
    assign part = a_reg * b_reg[B_PAD-1 -: TSS_CHUNK_W];

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NCH);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // operands and accumulator
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= B_PAD'(b);
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            b_reg   <= b_reg << TSS_CHUNK_W;
            acc_reg <= (acc_reg << TSS_CHUNK_W) + P_W'(part);
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

// ===== rtl/tss_div.sv =====
// ----------------------------------------------------------------------------
// tss_div
// Iterative radix-16 restoring divider. One quotient digit per cycle; the
// partial remainder stays below the divisor, so each step is a set of narrow
// compares against the divisor multiples and one subtract.
// ----------------------------------------------------------------------------
module tss_div
    import tss_pkg::*;
#(
    parameter int N_W = 46
) (
    input  logic                                                       clk,
    input  logic                                                       rst_n,
    input  logic                                                       start,
    input  logic [N_W-1:0]                                             dividend,
    input  logic [TSS_DIV_D_W-1:0]                                     divisor,
    output logic                                                       done,
    output logic [((N_W+TSS_DIGIT_W-1)/TSS_DIGIT_W)*TSS_DIGIT_W-1:0]   quot
);

    localparam int NSTEP = (N_W + TSS_DIGIT_W - 1) / TSS_DIGIT_W;
    localparam int N_PAD = NSTEP * TSS_DIGIT_W;
    localparam int R_W   = TSS_DIV_D_W + TSS_DIGIT_W;
    localparam int NDIG  = 1 << TSS_DIGIT_W;
    localparam int CNT_W = $clog2(NSTEP + 1);

    logic [N_PAD-1:0]       n_reg;
    logic [N_PAD-1:0]       q_reg;
    logic [TSS_DIV_D_W-1:0] d_reg;
    logic [TSS_DIV_D_W-1:0] rem_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic                   busy_reg;
    logic                   done_reg;

    logic [R_W-1:0]         pr;
    logic [R_W-1:0]         mult [NDIG];
    logic [TSS_DIGIT_W-1:0] digit;

    // partial remainder with the next dividend digit shifted in
    assign pr = {rem_reg, n_reg[N_PAD-1 -: TSS_DIGIT_W]};

    // divisor multiples and digit pick
    always_comb
    begin
        digit = '0;
        for (int k = 0; k < NDIG; k++)
        begin
            mult[k] = R_W'(d_reg) * R_W'(k);
        end
        for (int k = 1; k < NDIG; k++)
        begin
            if (pr >= mult[k])
            begin
                digit = TSS_DIGIT_W'(k);
            end
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NSTEP);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // remainder and quotient
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg   <= N_PAD'(dividend);
            d_reg   <= divisor;
            rem_reg <= '0;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            n_reg   <= n_reg << TSS_DIGIT_W;
            rem_reg <= TSS_DIV_D_W'(pr - mult[digit]);
            q_reg   <= {q_reg[N_PAD-TSS_DIGIT_W-1:0], digit};
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

// ===== rtl/tss_datapath.sv =====
// ----------------------------------------------------------------------------
// tss_datapath
// Fixed-point datapath: angle capture and range check, degree to radian
// conversion, x^2, series term recurrence on the shared multiplier and
// divider, signed accumulation and final rounding/saturation to Q1.30.
// ----------------------------------------------------------------------------
module tss_datapath
    import tss_pkg::*;
#(
    parameter int FRAC_BITS = TSS_FRAC_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic signed [15:0]           angle_deg,
    input  logic [TSS_THR_W-1:0]         thr,
    input  tss_cmd_t                     cmd,
    output tss_stat_t                    stat,
    output logic signed [31:0]           res_sine,
    output logic [TSS_USED_W-1:0]        res_used,
    output logic                         res_oor
);

    localparam int F      = FRAC_BITS;
    localparam int X_W    = F + 1;
    localparam int MUL_W  = F + 4;
    localparam int TERM_W = F + 4;
    localparam int SUM_W  = TERM_W + 1;
    localparam int N_W    = F + 16;
    localparam int P_W    = MUL_W + ((MUL_W + TSS_CHUNK_W - 1) / TSS_CHUNK_W) * TSS_CHUNK_W;
    localparam int Q_W    = ((N_W + TSS_DIGIT_W - 1) / TSS_DIGIT_W) * TSS_DIGIT_W;

    localparam int TH_LSH = (F > TSS_OUT_FRAC) ? F - TSS_OUT_FRAC : 0;
    localparam int TH_RSH = (F < TSS_OUT_FRAC) ? TSS_OUT_FRAC - F : 0;
    localparam int THR_W  = TSS_THR_W + TH_LSH;
    localparam int CMP_W  = (TERM_W > THR_W) ? TERM_W : THR_W;

    localparam int SH_R    = TH_LSH;
    localparam int SH_L    = TH_RSH;
    localparam int RND_POS = (SH_R > 0) ? SH_R - 1 : 0;
    localparam int SCL_W   = SUM_W + SH_L + 1;
    localparam logic [SCL_W-1:0] RND_ADD = (SH_R > 0) ? (SCL_W'(1) << RND_POS) : '0;
    localparam logic [SCL_W-1:0] ONE_OUT = SCL_W'(1) << TSS_OUT_FRAC;

    localparam logic [63:0]    PIQ      = tss_piq(F);
    localparam logic [P_W-1:0] X2_RND   = P_W'(1) << (F - 3);
    localparam logic [P_W-1:0] TERM_RND = P_W'(1) << (F - 1);
    localparam logic [P_W-1:0] CONV_RND = P_W'(TSS_HALF_TURN / 2);

    logic [15:0]             mag_reg;
    logic                    neg_reg;
    logic                    oor_reg;
    logic [X_W-1:0]          x_reg;
    logic [MUL_W-1:0]        x2_reg;
    logic [TERM_W-1:0]       term_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic [TSS_USED_W-1:0]   used_reg;
    logic                    sneg_reg;
    logic [SUM_W-1:0]        smag_reg;
    logic [SCL_W-1:0]        scaled_reg;

    logic [15:0]             raw_mag;
    logic [MUL_W-1:0]        mul_a;
    logic [MUL_W-1:0]        mul_b;
    logic [P_W-1:0]          prod;
    logic                    mul_done;
    logic [N_W-1:0]          div_n;
    logic [TSS_DIV_D_W-1:0]  div_d;
    logic [Q_W-1:0]          quot;
    logic                    div_done;
    logic [TSS_DIV_D_W-1:0]  half_d;
    logic [P_W-1:0]          term_add;
    logic [THR_W-1:0]        thr_f;
    logic signed [SUM_W-1:0] term_s;
    logic                    sub_term;
    logic [30:0]             sat_mag;
    logic [31:0]             sat_ext;

    // angle magnitude
    assign raw_mag = angle_deg[15] ? (~angle_deg + 16'd1) : angle_deg;

    // multiplier operand select
    always_comb
    begin
        unique case (cmd.mul_op)
            MUL_CONV:
            begin
                mul_a = MUL_W'(PIQ);
                mul_b = MUL_W'(mag_reg);
            end
            MUL_SQ:
            begin
                mul_a = MUL_W'(x_reg);
                mul_b = MUL_W'(x_reg);
            end
            MUL_TERM:
            begin
                mul_a = term_reg;
                mul_b = x2_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    tss_mul #(
        .A_W (MUL_W),
        .B_W (MUL_W)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.mul_go),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (prod)
    );

    // divider operand select; term rounding folded into one add
    assign half_d   = tss_half_divisor(cmd.term_idx);
    assign term_add = (P_W'(half_d) << F) | TERM_RND;

    always_comb
    begin
        unique case (cmd.div_op)
            DIV_CONV:
            begin
                div_n = N_W'(prod + CONV_RND);
                div_d = TSS_DIV_D_W'(TSS_HALF_TURN);
            end
            DIV_TERM:
            begin
                div_n = N_W'((prod + term_add) >> F);
                div_d = half_d << 1;
            end
            default:
            begin
                div_n = '0;
                div_d = '0;
            end
        endcase
    end

    tss_div #(
        .N_W (N_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_go),
        .dividend (div_n),
        .divisor  (div_d),
        .done     (div_done),
        .quot     (quot)
    );

    // threshold aligned to the term format
    assign thr_f = (THR_W'(thr) << TH_LSH) >> TH_RSH;

    // signed term for accumulation
    assign term_s   = $signed({1'b0, term_reg});
    assign sub_term = cmd.term_idx[0] ^ neg_reg;

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mag_reg  <= raw_mag;
            neg_reg  <= angle_deg[15];
            oor_reg  <= (raw_mag > 16'(TSS_HALF_TURN));
            sum_reg  <= '0;
            used_reg <= '0;
        end
        if (cmd.take_x)
        begin
            x_reg    <= X_W'(quot);
            term_reg <= TERM_W'(X_W'(quot)) << 1;
        end
        if (cmd.take_x2)
        begin
            x2_reg <= MUL_W'((prod + X2_RND) >> (F - 2));
        end
        if (cmd.take_term)
        begin
            term_reg <= TERM_W'(quot);
        end
        if (cmd.accum)
        begin
            sum_reg  <= sub_term ? (sum_reg - term_s) : (sum_reg + term_s);
            used_reg <= used_reg + TSS_USED_W'(1);
        end
        if (cmd.fin_abs)
        begin
            sneg_reg <= sum_reg[SUM_W-1];
            smag_reg <= sum_reg[SUM_W-1] ? $unsigned(-sum_reg) : $unsigned(sum_reg);
        end
        if (cmd.fin_rnd)
        begin
            scaled_reg <= ((SCL_W'(smag_reg) + RND_ADD) >> SH_R) << SH_L;
        end
    end

    // saturate to one and reapply sign
    assign sat_mag  = (scaled_reg > ONE_OUT) ? 31'h4000_0000 : scaled_reg[30:0];
    assign sat_ext  = {1'b0, sat_mag};
    assign res_sine = sneg_reg ? $signed(~sat_ext + 32'd1) : $signed(sat_ext);
    assign res_used = used_reg;
    assign res_oor  = oor_reg;

    // status
    assign stat.oor        = oor_reg;
    assign stat.term_small = CMP_W'(term_reg) <= CMP_W'(thr_f);
    assign stat.mul_done   = mul_done;
    assign stat.div_done   = div_done;

endmodule

// ===== rtl/tss_ctrl.sv =====
// ----------------------------------------------------------------------------
// tss_ctrl
// Sequencer for one angle at a time. In range: conversion, squaring, then
// one multiply/divide pair per series term until the term falls to the
// threshold or the term limit is reached; all angles end in result finishing.
// ----------------------------------------------------------------------------
module tss_ctrl
    import tss_pkg::*;
#(
    parameter int MAX_TERMS = TSS_MAX_TERMS
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  logic      out_free,
    output logic      result_load,
    output tss_cmd_t  cmd,
    input  tss_stat_t stat
);

    localparam logic [TSS_IDX_W-1:0] LAST_IDX = TSS_IDX_W'(MAX_TERMS - 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_CONV_MUL,
        S_CONV_DIV,
        S_SQ_START,
        S_SQ_MUL,
        S_CHECK,
        S_TERM_MUL,
        S_TERM_DIV,
        S_FIN_ABS,
        S_FIN_RND,
        S_OUTPUT
    } state_t;

    state_t               state_reg;
    state_t               state_next;
    logic [TSS_IDX_W-1:0] idx_reg;
    logic [TSS_IDX_W-1:0] idx_next;

    // next state and commands
    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        in_ready     = 1'b0;
        result_load  = 1'b0;
        cmd          = '0;
        cmd.mul_op   = MUL_CONV;
        cmd.div_op   = DIV_CONV;
        cmd.term_idx = idx_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    idx_next   = '0;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                if (stat.oor)
                begin
                    state_next = S_FIN_ABS;
                end
                else
                begin
                    cmd.mul_go = 1'b1;
                    cmd.mul_op = MUL_CONV;
                    state_next = S_CONV_MUL;
                end
            end
            S_CONV_MUL:
            begin
                if (stat.mul_done)
                begin
                    cmd.div_go = 1'b1;
                    cmd.div_op = DIV_CONV;
                    state_next = S_CONV_DIV;
                end
            end
            S_CONV_DIV:
            begin
                if (stat.div_done)
                begin
                    cmd.take_x = 1'b1;
                    state_next = S_SQ_START;
                end
            end
            S_SQ_START:
            begin
                cmd.mul_go = 1'b1;
                cmd.mul_op = MUL_SQ;
                state_next = S_SQ_MUL;
            end
            S_SQ_MUL:
            begin
                cmd.mul_op = MUL_SQ;
                if (stat.mul_done)
                begin
                    cmd.take_x2 = 1'b1;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.term_small)
                begin
                    state_next = S_FIN_ABS;
                end
                else
                begin
                    cmd.accum = 1'b1;
                    if (idx_reg == LAST_IDX)
                    begin
                        state_next = S_FIN_ABS;
                    end
                    else
                    begin
                        cmd.mul_go = 1'b1;
                        cmd.mul_op = MUL_TERM;
                        idx_next   = idx_reg + TSS_IDX_W'(1);
                        state_next = S_TERM_MUL;
                    end
                end
            end
            S_TERM_MUL:
            begin
                cmd.mul_op = MUL_TERM;
                cmd.div_op = DIV_TERM;
                if (stat.mul_done)
                begin
                    cmd.div_go = 1'b1;
                    state_next = S_TERM_DIV;
                end
            end
            S_TERM_DIV:
            begin
                cmd.div_op = DIV_TERM;
                if (stat.div_done)
                begin
                    cmd.take_term = 1'b1;
                    state_next    = S_CHECK;
                end
            end
            S_FIN_ABS:
            begin
                cmd.fin_abs = 1'b1;
                state_next  = S_FIN_RND;
            end
            S_FIN_RND:
            begin
                cmd.fin_rnd = 1'b1;
                state_next  = S_OUTPUT;
            end
            S_OUTPUT:
            begin
                if (out_free)
                begin
                    result_load = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and term index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

endmodule
